### src/ed_pkg.sv
// ----------------------------------------------------------------------------
// ed_pkg
// Shared types and helpers for the edit distance block.
// ----------------------------------------------------------------------------
package ed_pkg;

  localparam logic [7:0] UpperFirst = 8'h41;
  localparam logic [7:0] UpperLast  = 8'h5A;
  localparam logic [7:0] CaseOffset = 8'h20;

  // Register byte addresses of the configuration port.
  localparam logic [2:0] RegIgnoreCase = 3'd0;

  // What one cell hands to its right-hand neighbor besides the row values.
  typedef struct packed {
    logic       valid;
    logic [7:0] char_code;
  } link_t;

  function automatic logic [7:0] fold_char(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && (c inside {[UpperFirst:UpperLast]})) begin
      r = c + CaseOffset;
    end
    return r;
  endfunction

endpackage

### src/ed_in_if.sv
// ----------------------------------------------------------------------------
// ed_in_if
// Input channel: one string byte or an empty-string marker per beat.
// ----------------------------------------------------------------------------
interface ed_in_if;
  logic       valid;
  logic       ready;
  logic       side;
  logic [7:0] char_code;
  logic       end_of_string;
  logic       empty_string;

  modport source (output valid, side, char_code, end_of_string, empty_string,
                  input ready);
  modport sink   (input valid, side, char_code, end_of_string, empty_string,
                  output ready);
endinterface

### src/ed_out_if.sv
// ----------------------------------------------------------------------------
// ed_out_if
// Result channel: one distance and overflow flag per string pair.
// ----------------------------------------------------------------------------
interface ed_out_if #(parameter int unsigned DistW = 7);
  logic             valid;
  logic             ready;
  logic [DistW-1:0] distance;
  logic             overflow;

  modport source (output valid, distance, overflow, input ready);
  modport sink   (input valid, distance, overflow, output ready);
endinterface

### src/ed_cell.sv
// ----------------------------------------------------------------------------
// ed_cell
// One column of the distance table: holds a left byte and its row value.
// ----------------------------------------------------------------------------
module ed_cell #(
  parameter int unsigned ValW  = 7,
  parameter int unsigned Index = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fold_i,
  input  logic            init_i,
  input  logic            wr_en_i,
  input  logic [7:0]      wr_byte_i,
  input  ed_pkg::link_t   link_i,
  input  logic [ValW-1:0] new_i,
  input  logic [ValW-1:0] old_i,
  output ed_pkg::link_t   link_o,
  output logic [ValW-1:0] new_o,
  output logic [ValW-1:0] old_o
);

  logic [7:0]      byte_q;
  logic [ValW-1:0] dp_q, dp_d;
  logic [ValW-1:0] old_q;
  logic            link_valid_q;
  logic [7:0]      link_char_q;
  logic            match;
  logic [ValW-1:0] min_v;

  always_comb begin
    match = ed_pkg::fold_char(byte_q, fold_i) == ed_pkg::fold_char(link_i.char_code, fold_i);
    min_v = new_i;
    if (dp_q < min_v) min_v = dp_q;
    if (old_i < min_v) min_v = old_i;
    dp_d = match ? old_i : min_v + ValW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dp_q         <= ValW'(Index);
      link_valid_q <= 1'b0;
    end else if (init_i) begin
      dp_q         <= ValW'(Index);
      link_valid_q <= 1'b0;
    end else begin
      link_valid_q <= link_i.valid;
      if (link_i.valid) begin
        dp_q <= dp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      byte_q <= wr_byte_i;
    end
    if (link_i.valid) begin
      old_q       <= dp_q;
      link_char_q <= link_i.char_code;
    end
  end

  assign link_o = '{valid: link_valid_q, char_code: link_char_q};
  assign new_o  = dp_q;
  assign old_o  = old_q;

endmodule

### src/edit_distance.sv
// Result: registered once the drain counter reaches L, L = left length, and the output is free.
// Throughput: one byte per cycle on both strings while loading; a right byte walks the cell row one
// cell per cycle, and input is held off while the last byte reaches cell L and until the result is captured.
// Reset: asynchronous, active low; the row returns to its index values at once, and stored
// left bytes stay undefined until written.
// ----------------------------------------------------------------------------
// edit_distance
// Levenshtein distance of two byte strings on a systolic row of cells.
// ----------------------------------------------------------------------------
module edit_distance #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  ed_in_if.sink              in_i,
  ed_out_if.source           out_o,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [2:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  output logic [31:0]        prdata_o,
  output logic               pready_o
);

  localparam int unsigned ValW = $clog2(MAX_LEN + 1);
  localparam logic [ValW-1:0] MaxVal = ValW'(MAX_LEN);

  localparam logic StLoad  = 1'b0;
  localparam logic StDrain = 1'b1;

  logic            state_q, state_d;
  logic            loading_q, loading_d;
  logic [ValW-1:0] left_len_q, left_len_d;
  logic [ValW-1:0] right_cnt_q, right_cnt_d;
  logic            ovf_q, ovf_d;
  logic [ValW-1:0] cnt_q, cnt_d;
  logic            ignore_case_q;

  ed_pkg::link_t   head_link_d;
  logic            head_valid_q;
  logic [7:0]      head_char_q;
  logic [ValW-1:0] head_old_q;

  logic            out_valid_q, out_valid_d;
  logic [ValW-1:0] out_dist_q;
  logic            out_ovf_q;

  logic            in_fire, left_wr, capture, init_row;
  logic [ValW-1:0] dp_sel;

  ed_pkg::link_t   link   [0:MAX_LEN];
  logic [ValW-1:0] new_v  [0:MAX_LEN];
  logic [ValW-1:0] old_v  [0:MAX_LEN];

  // Configuration port.
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i == ed_pkg::RegIgnoreCase) ? {31'd0, ignore_case_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ignore_case_q <= 1'b0;
    end else if (psel_i && penable_i && pwrite_i && paddr_i == ed_pkg::RegIgnoreCase) begin
      ignore_case_q <= pwdata_i[0];
    end
  end

  assign in_i.ready = (state_q == StLoad);
  assign in_fire    = in_i.valid && in_i.ready;

  assign dp_sel  = new_v[left_len_q];
  assign capture = (state_q == StDrain) && (cnt_q == left_len_q) &&
                   (!out_valid_q || out_o.ready);
  assign init_row = capture;
  assign left_wr  = in_fire && !loading_q && (in_i.side == loading_q) &&
                    !in_i.empty_string && (left_len_q < MaxVal);

  always_comb begin
    state_d     = state_q;
    loading_d   = loading_q;
    left_len_d  = left_len_q;
    right_cnt_d = right_cnt_q;
    ovf_d       = ovf_q;
    cnt_d       = cnt_q;
    head_link_d = '{valid: 1'b0, char_code: head_char_q};
    out_valid_d = out_valid_q && !out_o.ready;

    if (in_fire && (in_i.side == loading_q)) begin
      if (!loading_q) begin
        if (!in_i.empty_string) begin
          if (left_len_q < MaxVal) left_len_d = left_len_q + ValW'(1);
          else                     ovf_d      = 1'b1;
        end
        if (in_i.empty_string || in_i.end_of_string) loading_d = 1'b1;
      end else begin
        if (!in_i.empty_string) begin
          if (right_cnt_q < MaxVal) begin
            head_link_d.valid     = 1'b1;
            head_link_d.char_code = in_i.char_code;
            right_cnt_d           = right_cnt_q + ValW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        if (in_i.empty_string || in_i.end_of_string) begin
          state_d = StDrain;
          cnt_d   = '0;
        end
      end
    end

    if (state_q == StDrain) begin
      if (cnt_q != left_len_q) cnt_d = cnt_q + ValW'(1);
      if (capture) begin
        out_valid_d = 1'b1;
        state_d     = StLoad;
        loading_d   = 1'b0;
        left_len_d  = '0;
        right_cnt_d = '0;
        ovf_d       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StLoad;
      loading_q    <= 1'b0;
      left_len_q   <= '0;
      right_cnt_q  <= '0;
      ovf_q        <= 1'b0;
      cnt_q        <= '0;
      head_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      loading_q    <= loading_d;
      left_len_q   <= left_len_d;
      right_cnt_q  <= right_cnt_d;
      ovf_q        <= ovf_d;
      cnt_q        <= cnt_d;
      head_valid_q <= head_link_d.valid;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_link_d.valid) begin
      head_char_q <= head_link_d.char_code;
      head_old_q  <= right_cnt_q;
    end
    if (capture) begin
      out_dist_q <= ovf_q ? MaxVal : dp_sel;
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.distance = out_dist_q;
  assign out_o.overflow = out_ovf_q;

  // Column zero of the row is the right byte count itself.
  assign link[0]  = '{valid: head_valid_q, char_code: head_char_q};
  assign new_v[0] = right_cnt_q;
  assign old_v[0] = head_old_q;

  for (genvar i = 1; i <= MAX_LEN; i++) begin : g_cell
    ed_cell #(
      .ValW  (ValW),
      .Index (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .fold_i    (ignore_case_q),
      .init_i    (init_row),
      .wr_en_i   (left_wr && (left_len_q == ValW'(i - 1))),
      .wr_byte_i (in_i.char_code),
      .link_i    (link[i-1]),
      .new_i     (new_v[i-1]),
      .old_i     (old_v[i-1]),
      .link_o    (link[i]),
      .new_o     (new_v[i]),
      .old_o     (old_v[i])
    );
  end

  // The drain counter never runs past the left length.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDrain) |-> (cnt_q <= left_len_q))
    else $error("drain counter passed the left length");

  // The right count only moves once the left string has ended.
  a_right_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !loading_q |-> (right_cnt_q == '0))
    else $error("right count nonzero while loading left string");

  // Draining only follows a right string.
  a_drain_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDrain) |-> loading_q)
    else $error("drain entered without a right string");

  // A result waiting at the output is never overwritten.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_dist_q)))
    else $error("pending result changed");

  // Lengths stay within the cell row.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_len_q <= MaxVal) && (right_cnt_q <= MaxVal))
    else $error("length counter beyond MAX_LEN");

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for edit_distance. Byte beats are streamed in from a
// queue and each one is scored by a local Levenshtein predictor on
// acceptance. Returned distances are compared in order against those
// predictions, with random gaps on both channels and one long result stall.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned MaxLen       = 64;
  localparam int unsigned SettleCycles = MaxLen + 8;
  localparam int unsigned IdleLimit    = 4000;
  localparam int unsigned HoldAt       = 500;
  localparam int unsigned HoldCycles   = 400;

  typedef struct packed {
    logic       side;
    logic [7:0] char_code;
    logic       eos;
    logic       empty;
  } beat_t;

  typedef struct packed {
    logic [6:0] distance;
    logic       overflow;
  } result_t;

  typedef logic [7:0] str_t[$];

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        psel_i;
  logic        penable_i;
  logic        pwrite_i;
  logic [2:0]  paddr_i;
  logic [31:0] pwdata_i;
  logic [31:0] prdata_o;
  logic        pready_o;

  ed_in_if               in_ch ();
  ed_out_if #(.DistW(7)) res_ch ();

  edit_distance #(.MAX_LEN(MaxLen)) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_o     (res_ch),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Predictor state.
  logic [7:0] left_mem [MaxLen];
  logic [6:0] left_len;
  logic [6:0] right_len;
  logic [6:0] row [MaxLen+1];
  logic       on_right;
  logic       too_long;
  logic       fold_en;

  beat_t       beat_q[$];
  result_t     dist_q[$];
  int unsigned n_stim = 0;
  int unsigned n_bytes = 0;
  int unsigned n_ignored = 0;
  int unsigned n_results = 0;
  int unsigned n_ovf = 0;
  int unsigned n_errors = 0;
  bit          calm;

  function automatic logic [7:0] lower(input logic [7:0] c);
    if (fold_en && c >= ed_pkg::UpperFirst && c <= ed_pkg::UpperLast) begin
      return c + ed_pkg::CaseOffset;
    end
    return c;
  endfunction

  function automatic void clear_row();
    for (int i = 0; i <= MaxLen; i++) begin
      row[i] = 7'(i);
    end
  endfunction

  // One right byte sweeps the row up to the left length; row[i-1] already holds its new value.
  function automatic void add_right_byte(input logic [7:0] c);
    logic [6:0] diag, up, best;
    logic [7:0] fc;
    diag = row[0];
    fc = lower(c);
    right_len = right_len + 7'd1;
    row[0] = right_len;
    for (int i = 1; i <= int'(left_len); i++) begin
      up = row[i];
      if (lower(left_mem[i-1]) == fc) begin
        row[i] = diag;
      end else begin
        best = row[i-1];
        if (up < best) best = up;
        if (diag < best) best = diag;
        row[i] = best + 7'd1;
      end
      diag = up;
    end
  endfunction

  function automatic bit levenshtein_step(input beat_t b, output result_t r);
    r = '0;
    if (b.side != on_right) return 1'b0;
    if (!on_right) begin
      if (!b.empty) begin
        if (left_len < MaxLen) begin
          left_mem[left_len] = b.char_code;
          left_len = left_len + 7'd1;
        end else begin
          too_long = 1'b1;
        end
      end
      if (b.empty || b.eos) begin
        on_right = 1'b1;
        right_len = '0;
        clear_row();
      end
      return 1'b0;
    end
    if (!b.empty) begin
      if (right_len < MaxLen) add_right_byte(b.char_code);
      else too_long = 1'b1;
    end
    if (b.empty || b.eos) begin
      r.distance = too_long ? 7'(MaxLen) : row[left_len];
      r.overflow = too_long;
      left_len = '0;
      right_len = '0;
      on_right = 1'b0;
      too_long = 1'b0;
      clear_row();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // ---------------- stimulus construction ----------------

  function automatic void push_beat(input logic side, input logic [7:0] c, input logic eos,
                                    input logic empty);
    beat_t b;
    b.side = side;
    b.char_code = c;
    b.eos = eos;
    b.empty = empty;
    beat_q = {beat_q, b};
    n_stim++;
  endfunction

  // A beat for the side that is not being loaded; the block must drop it.
  function automatic void push_ignored(input logic side);
    beat_t b;
    b.side = side;
    b.char_code = 8'($urandom);
    b.eos = 1'($urandom);
    b.empty = 1'($urandom);
    beat_q = {beat_q, b};
    n_ignored++;
  endfunction

  function automatic void push_string(input logic side, input str_t s, input bit marker_end,
                                      input bit noisy);
    for (int i = 0; i <= s.size(); i++) begin
      if (noisy && $urandom_range(0, 19) == 0) push_ignored(!side);
      if (i < s.size()) begin
        push_beat(side, s[i], !marker_end && i == s.size() - 1, 1'b0);
        n_bytes++;
      end else if (marker_end || s.size() == 0) begin
        push_beat(side, 8'($urandom), 1'($urandom), 1'b1);
      end
    end
  endfunction

  function automatic int pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, 8);
    if (r < 97) return $urandom_range(9, MaxLen);
    return $urandom_range(MaxLen + 1, MaxLen + 4);
  endfunction

  // Mostly a few letters in both cases so that folding matters.
  function automatic logic [7:0] pick_byte();
    logic [7:0] pool [8];
    pool = '{8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        return ed_pkg::UpperFirst + 8'($urandom_range(0, 2)) +
               ($urandom_range(0, 1) ? ed_pkg::CaseOffset : 8'h00);
      end
      5, 6: begin
        return pool[$urandom_range(0, 7)];
      end
      default: begin
        return 8'($urandom_range(0, 255));
      end
    endcase
  endfunction

  // A negative length picks one at random; half of the random right strings
  // are a few edits away from the left one.
  function automatic void push_random_pair(input int left_n, input int right_n);
    str_t lhs, rhs;
    int unsigned pos;
    if (left_n < 0) left_n = pick_len();
    for (int i = 0; i < left_n; i++) lhs = {lhs, pick_byte()};
    if (right_n < 0 && $urandom_range(0, 1) == 1) begin
      rhs = lhs;
      repeat ($urandom_range(0, 3)) begin
        pos = $urandom_range(0, rhs.size());
        case ($urandom_range(0, 2))
          0: rhs.insert(pos, pick_byte());
          1: if (pos < rhs.size()) rhs.delete(pos);
          default: if (pos < rhs.size()) rhs[pos] = pick_byte();
        endcase
      end
    end else begin
      if (right_n < 0) right_n = pick_len();
      for (int i = 0; i < right_n; i++) rhs = {rhs, pick_byte()};
    end
    push_string(1'b0, lhs, $urandom_range(0, 9) == 0, 1'b1);
    push_string(1'b1, rhs, $urandom_range(0, 9) == 0, 1'b1);
  endfunction

  // ---------------- configuration port ----------------

  task automatic set_ignore_case(input logic v);
    logic [31:0] wdata;
    wdata = $urandom;
    wdata[0] = v;
    @(posedge clk_i);
    psel_i <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i <= 1'b1;
    paddr_i <= ed_pkg::RegIgnoreCase;
    pwdata_i <= wdata;
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    fold_en = v;
    penable_i <= 1'b0;
    pwrite_i <= 1'b0;
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(negedge clk_i); while (!pready_o);
    if (prdata_o !== {31'b0, v}) begin
      report_mismatch("ignore_case readback", int'(prdata_o), int'(v));
    end
    @(posedge clk_i);
    psel_i <= 1'b0;
    penable_i <= 1'b0;
  endtask

  // Waits until every beat is taken and every distance is back, then lets
  // the row settle before anything else changes.
  task automatic drain();
    do @(negedge clk_i); while (beat_q.size() != 0 || in_ch.valid || dist_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // ---------------- driver ----------------

  beat_t       drv_beat;
  result_t     drv_res;
  int unsigned drv_gap;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.side <= 1'b0;
      in_ch.char_code <= '0;
      in_ch.end_of_string <= 1'b0;
      in_ch.empty_string <= 1'b0;
      drv_gap = 0;
      left_len = '0;
      right_len = '0;
      on_right = 1'b0;
      too_long = 1'b0;
      clear_row();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (levenshtein_step(drv_beat, drv_res)) dist_q = {dist_q, drv_res};
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_ch.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 15) == 0) begin
          drv_gap = $urandom_range(1, 10) - 1;
          in_ch.valid <= 1'b0;
        end else if (beat_q.size() != 0) begin
          drv_beat = beat_q.pop_front();
          in_ch.side <= drv_beat.side;
          in_ch.char_code <= drv_beat.char_code;
          in_ch.end_of_string <= drv_beat.eos;
          in_ch.empty_string <= drv_beat.empty;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------

  result_t     mon_want;
  int unsigned mon_seen_in, mon_hold, mon_stall;
  bit          mon_held;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      mon_seen_in = 0;
      mon_hold = 0;
      mon_stall = 0;
      mon_held = 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) mon_seen_in++;
      if (res_ch.valid && res_ch.ready) begin
        n_results++;
        if (res_ch.overflow) n_ovf++;
        if (dist_q.size() == 0) begin
          report_mismatch("distance with none expected", int'(res_ch.distance), -1);
        end else begin
          mon_want = dist_q.pop_front();
          if (res_ch.distance !== mon_want.distance) begin
            report_mismatch("distance", int'(res_ch.distance), int'(mon_want.distance));
          end
          if (res_ch.overflow !== mon_want.overflow) begin
            report_mismatch("overflow", int'(res_ch.overflow), int'(mon_want.overflow));
          end
        end
      end
      // One long stall while input keeps coming, so the block backs up.
      if (!mon_held && mon_seen_in >= HoldAt) begin
        mon_held = 1'b1;
        mon_hold = HoldCycles;
      end
      if (mon_hold > 0) begin
        mon_hold--;
        res_ch.ready <= 1'b0;
      end else if (mon_stall > 0) begin
        mon_stall--;
        res_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        mon_stall = $urandom_range(1, 10) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------- watchdog ----------------

  int unsigned idle_cycles;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) || psel_i)
    begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------- sequence ----------------

  initial begin
    str_t lhs, rhs;
    psel_i = 1'b0;
    penable_i = 1'b0;
    pwrite_i = 1'b0;
    paddr_i = '0;
    pwdata_i = '0;
    calm = 1'b0;
    fold_en = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pairs with case folding off.
    set_ignore_case(1'b0);
    lhs = {};
    rhs = {};
    push_string(1'b0, lhs, 1'b0, 1'b0);
    push_string(1'b1, rhs, 1'b0, 1'b0);
    lhs = {8'h41};
    rhs = {8'h61};
    push_string(1'b0, lhs, 1'b0, 1'b0);
    push_string(1'b1, rhs, 1'b0, 1'b0);
    // Extreme bytes, with a wrong-side beat in front of each half.
    push_ignored(1'b1);
    lhs = {8'h00, 8'hFF};
    push_string(1'b0, lhs, 1'b0, 1'b0);
    push_ignored(1'b0);
    rhs = {8'hFF};
    push_string(1'b1, rhs, 1'b0, 1'b0);
    // The empty marker closes a side that already has bytes.
    lhs = {8'h61, 8'h62};
    rhs = {8'h61, 8'h62, 8'h63};
    push_string(1'b0, lhs, 1'b1, 1'b0);
    push_string(1'b1, rhs, 1'b1, 1'b0);
    lhs = {};
    rhs = {8'h78, 8'h79};
    push_string(1'b0, lhs, 1'b0, 1'b0);
    push_string(1'b1, rhs, 1'b0, 1'b0);
    lhs = {8'h40, 8'h5A, 8'h5B};
    rhs = {8'h60, 8'h7A, 8'h7B};
    push_string(1'b0, lhs, 1'b0, 1'b0);
    push_string(1'b1, rhs, 1'b0, 1'b0);
    drain();

    // Folding on: the case pairs again, full-length and overlong strings.
    set_ignore_case(1'b1);
    lhs = {8'h41};
    rhs = {8'h61};
    push_string(1'b0, lhs, 1'b0, 1'b0);
    push_string(1'b1, rhs, 1'b0, 1'b0);
    lhs = {8'h40, 8'h5A, 8'h5B};
    rhs = {8'h60, 8'h7A, 8'h7B};
    push_string(1'b0, lhs, 1'b0, 1'b0);
    push_string(1'b1, rhs, 1'b0, 1'b0);
    push_random_pair(MaxLen, MaxLen);
    push_random_pair(MaxLen + 2, 3);
    push_random_pair(2, MaxLen + 1);
    push_random_pair(MaxLen + 1, MaxLen + 1);
    while (n_stim < 350) push_random_pair(-1, -1);
    drain();

    set_ignore_case(1'b0);
    while (n_stim < 700) push_random_pair(-1, -1);
    drain();

    // Last stretch runs without gaps on either side.
    set_ignore_case(1'b1);
    calm = 1'b1;
    while (n_stim < 1000) push_random_pair(-1, -1);
    drain();

    $display("Checked %0d distances (%0d overflowed) from %0d string bytes and %0d dropped beats,",
             n_results, n_ovf, n_bytes, n_ignored);
    $display("with case folding off and on and one %0d-cycle result stall.", HoldCycles);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
